// ===== src/sris_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the shred ring store index.
// No dependencies; used by every module of the block.
package sris_pkg;

  localparam int RING_DEPTH        = 1024;
  localparam int RING_AW           = $clog2(RING_DEPTH);
  localparam int CNT_W             = RING_AW + 1;
  localparam int MAX_PAYLOAD_BYTES = 1228;
  localparam int SLOT_BITS         = 48;
  localparam int INDEX_BITS        = 15;
  localparam int LEN_BITS          = 11;
  localparam int KEY_BITS          = SLOT_BITS + INDEX_BITS;
  localparam int CAP_BITS          = 11;

  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_QUERY   = 2'd1,
    MODE_HIGHEST = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_DUP      = 3'd1,
    ST_FOUND    = 3'd2,
    ST_MISS     = 3'd3,
    ST_TOOBIG   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_FIN  = 2'd2
  } state_e;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [LEN_BITS-1:0] len;
  } ring_entry_t;

  typedef struct packed {
    logic load;
    logic scan_en;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } sts_t;

endpackage

// ===== src/shred_ring_store_index.sv =====
`timescale 1ns / 1ps
// Top level of the shred ring store index: stream ports, APB register,
// controller and datapath. Depends on sris_pkg, sris_ctrl, sris_dp.
//
// One item at a time. Every operation reads the whole written part of the
// ring through the single read port of the ring memory, one position a
// cycle, before it answers. The written part holds the ring positions
// written since reset (up to 1024). The answer is committed once the scan
// is done and the output register is free, so it waits while the output
// stalls. A finished word sits in an output register, so the next item
// may start while it waits to be taken.
module shred_ring_store_index (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // slot[47:0], shred_index[62:48], payload_bytes[73:63]
  input  logic [1:0]  s_axis_tuser,  // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // ring_position[9:0], stored_bytes[20:10],
                                     // found_index[35:21], evicted[36]
  output logic [2:0]  m_axis_tuser,  // status[2:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sris_pkg::cmd_t cmd;
  sris_pkg::sts_t sts;

  logic [sris_pkg::CAP_BITS-1:0] cap_q;
  logic [2:0]                    status;
  logic [sris_pkg::RING_AW-1:0]  pos;
  logic [sris_pkg::LEN_BITS-1:0] bytes;
  logic [sris_pkg::INDEX_BITS-1:0] idx;
  logic                          ev;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {21'd0, cap_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= sris_pkg::CAP_BITS'(sris_pkg::RING_DEPTH);
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      cap_q <= pwdata[sris_pkg::CAP_BITS-1:0];
    end
  end

  sris_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sris_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i         (cmd),
    .sts_o         (sts),
    .mode_i        (s_axis_tuser),
    .slot_i        (s_axis_tdata[47:0]),
    .index_i       (s_axis_tdata[62:48]),
    .bytes_i       (s_axis_tdata[73:63]),
    .cap_i         (cap_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_status_o  (status),
    .out_pos_o     (pos),
    .out_bytes_o   (bytes),
    .out_index_o   (idx),
    .out_evicted_o (ev)
  );

  assign m_axis_tuser = status;
  assign m_axis_tdata = {3'd0, ev, idx, bytes, pos};

endmodule

// ===== src/sris_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the shred ring store index: accept, ring scan, commit.
// Depends on sris_pkg.
module sris_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sris_pkg::sts_t sts_i,
  output sris_pkg::cmd_t cmd_o
);

  sris_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sris_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      sris_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sris_pkg::S_SCAN;
        end
      end
      sris_pkg::S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_done) begin
          state_d = sris_pkg::S_FIN;
        end
      end
      sris_pkg::S_FIN: begin
        // wait for the output register to free up
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = sris_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sris_pkg::S_IDLE;
      end
    endcase
  end

  a_commit_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> $past(state_q) == sris_pkg::S_SCAN || $past(state_q) == sris_pkg::S_FIN)
    else $error("commit without a completed scan");
  a_load_leads_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == sris_pkg::S_SCAN)
    else $error("load did not start a scan");
  a_no_commit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> !sts_i.out_busy)
    else $error("commit while output word pending");

endmodule

// ===== src/sris_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the shred ring store index: ring memory, scan compare,
// write pointer, fill count and output register. Depends on sris_pkg.
module sris_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sris_pkg::cmd_t                    cmd_i,
  output sris_pkg::sts_t                    sts_o,
  input  logic [1:0]                        mode_i,
  input  logic [sris_pkg::SLOT_BITS-1:0]    slot_i,
  input  logic [sris_pkg::INDEX_BITS-1:0]   index_i,
  input  logic [sris_pkg::LEN_BITS-1:0]     bytes_i,
  input  logic [sris_pkg::CAP_BITS-1:0]     cap_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2:0]                        out_status_o,
  output logic [sris_pkg::RING_AW-1:0]      out_pos_o,
  output logic [sris_pkg::LEN_BITS-1:0]     out_bytes_o,
  output logic [sris_pkg::INDEX_BITS-1:0]   out_index_o,
  output logic                              out_evicted_o
);

  localparam int AW = sris_pkg::RING_AW;
  localparam int CW = sris_pkg::CNT_W;
  localparam int IB = sris_pkg::INDEX_BITS;
  localparam int LB = sris_pkg::LEN_BITS;

  sris_pkg::ring_entry_t ring_mem [sris_pkg::RING_DEPTH];
  sris_pkg::ring_entry_t rd_q;

  logic [1:0]                     mode_q;
  logic [sris_pkg::SLOT_BITS-1:0] slot_q;
  logic [IB-1:0]                  index_q;
  logic [LB-1:0]                  bytes_q;

  logic [AW-1:0] wp_q, wp_d;
  logic [CW-1:0] filled_q, filled_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          inflight_q, inflight_d;
  logic [AW-1:0] rd_pos_q;

  logic          hit_q, best_v_q;
  logic [AW-1:0] hit_pos_q, best_pos_q;
  logic [LB-1:0] hit_len_q, best_len_q;
  logic [IB-1:0] best_idx_q;

  logic          out_valid_q;
  logic [2:0]    out_status_q;
  logic [AW-1:0] out_pos_q;
  logic [LB-1:0] out_bytes_q;
  logic [IB-1:0] out_index_q;
  logic          out_ev_q;

  logic          issue;
  logic          key_hit, slot_hit;
  logic          do_write;
  logic [CW-1:0] cap_eff;
  logic [CW-1:0] wp_inc;

  logic [2:0]    res_status;
  logic [AW-1:0] res_pos;
  logic [LB-1:0] res_bytes;
  logic [IB-1:0] res_index;
  logic          res_ev;

  assign issue    = cmd_i.scan_en && (cnt_q < filled_q);
  assign key_hit  = (rd_q.key == {slot_q, index_q});
  assign slot_hit = (rd_q.key[sris_pkg::KEY_BITS-1:IB] == slot_q);

  assign sts_o.scan_done = !(cnt_q < filled_q) && !inflight_q;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  // capacity 0 acts as 1, anything above the ring depth as the depth
  always_comb begin
    if (cap_i == '0) begin
      cap_eff = CW'(1);
    end else if (CW'(cap_i) > CW'(sris_pkg::RING_DEPTH)) begin
      cap_eff = CW'(sris_pkg::RING_DEPTH);
    end else begin
      cap_eff = CW'(cap_i);
    end
  end

  assign wp_inc = {1'b0, wp_q} + CW'(1);

  always_comb begin
    res_status = sris_pkg::ST_MISS;
    res_pos    = '0;
    res_bytes  = '0;
    res_index  = '0;
    res_ev     = 1'b0;
    do_write   = 1'b0;
    case (mode_q)
      sris_pkg::MODE_INSERT: begin
        if (bytes_q > LB'(sris_pkg::MAX_PAYLOAD_BYTES)) begin
          res_status = sris_pkg::ST_TOOBIG;
        end else if (hit_q) begin
          res_status = sris_pkg::ST_DUP;
          res_pos    = hit_pos_q;
          res_bytes  = hit_len_q;
          res_index  = index_q;
        end else begin
          res_status = sris_pkg::ST_INSERTED;
          res_pos    = wp_q;
          res_bytes  = bytes_q;
          res_index  = index_q;
          res_ev     = ({1'b0, wp_q} < filled_q);
          do_write   = 1'b1;
        end
      end
      sris_pkg::MODE_QUERY: begin
        if (hit_q) begin
          res_status = sris_pkg::ST_FOUND;
          res_pos    = hit_pos_q;
          res_bytes  = hit_len_q;
          res_index  = index_q;
        end
      end
      sris_pkg::MODE_HIGHEST: begin
        if (best_v_q && best_idx_q >= index_q) begin
          res_status = sris_pkg::ST_FOUND;
          res_pos    = best_pos_q;
          res_bytes  = best_len_q;
          res_index  = best_idx_q;
        end
      end
      default: begin
        res_status = sris_pkg::ST_MISS;
      end
    endcase
  end

  always_comb begin
    cnt_d      = cnt_q;
    inflight_d = issue;
    wp_d       = wp_q;
    filled_d   = filled_q;
    if (cmd_i.load) begin
      cnt_d = '0;
    end else if (issue) begin
      cnt_d = cnt_q + CW'(1);
    end
    if (cmd_i.commit && do_write) begin
      wp_d = (wp_inc >= cap_eff) ? '0 : wp_inc[AW-1:0];
      if ({1'b0, wp_q} == filled_q) begin
        filled_d = filled_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      filled_q    <= '0;
      cnt_q       <= '0;
      inflight_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      best_v_q    <= 1'b0;
    end else begin
      wp_q       <= wp_d;
      filled_q   <= filled_d;
      cnt_q      <= cnt_d;
      inflight_q <= inflight_d;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        hit_q    <= 1'b0;
        best_v_q <= 1'b0;
      end else if (inflight_q) begin
        if (key_hit) begin
          hit_q <= 1'b1;
        end
        if (slot_hit && (!best_v_q || rd_q.key[IB-1:0] > best_idx_q)) begin
          best_v_q <= 1'b1;
        end
      end
    end
  end

  // payload, scan-result and output registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      slot_q  <= slot_i;
      index_q <= index_i;
      bytes_q <= bytes_i;
    end
    rd_pos_q <= cnt_q[AW-1:0];
    if (inflight_q) begin
      if (key_hit) begin
        hit_pos_q <= rd_pos_q;
        hit_len_q <= rd_q.len;
      end
      if (slot_hit && (!best_v_q || rd_q.key[IB-1:0] > best_idx_q)) begin
        best_idx_q <= rd_q.key[IB-1:0];
        best_pos_q <= rd_pos_q;
        best_len_q <= rd_q.len;
      end
    end
    if (cmd_i.commit) begin
      out_status_q <= res_status;
      out_pos_q    <= res_pos;
      out_bytes_q  <= res_bytes;
      out_index_q  <= res_index;
      out_ev_q     <= res_ev;
    end
  end

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && do_write) begin
      ring_mem[wp_q] <= '{key: {slot_q, index_q}, len: bytes_q};
    end
    if (issue) begin
      rd_q <= ring_mem[cnt_q[AW-1:0]];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_pos_o     = out_pos_q;
  assign out_bytes_o   = out_bytes_q;
  assign out_index_o   = out_index_q;
  assign out_evicted_o = out_ev_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= CW'(sris_pkg::RING_DEPTH))
    else $error("fill count beyond ring depth");
  a_wp_in_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, wp_q} <= filled_q)
    else $error("write pointer beyond written prefix");
  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("commit did not load the output register");

endmodule

// ===== dv/tb_shred_ring_store_index.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for shred_ring_store_index: drives stream words and
// APB writes, predicts each answer with a behavioral copy of the index.
// Depends on sris_pkg and the block's top level.
module tb_shred_ring_store_index;

  localparam int TBL = 2048;
  localparam logic [2:0] ADDR_CAP = 3'd0;

  typedef struct packed {
    sris_pkg::status_e   status;
    logic [9:0]          pos;
    logic [10:0]         bytes;
    logic [14:0]         idx;
    logic                ev;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [79:0] s_axis_tdata = '0;  // slot[47:0], shred_index[62:48], payload_bytes[73:63]
  logic [1:0]  s_axis_tuser = '0;  // mode[1:0]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;       // ring_position[9:0], stored_bytes[20:10],
                                   // found_index[35:21], evicted[36]
  logic [2:0]  m_axis_tuser;       // status[2:0]
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  shred_ring_store_index i_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [sris_pkg::KEY_BITS-1:0]  rk_key [sris_pkg::RING_DEPTH];
  logic [sris_pkg::LEN_BITS-1:0]  rk_len [sris_pkg::RING_DEPTH];
  logic                           rk_occ [sris_pkg::RING_DEPTH];
  logic [sris_pkg::KEY_BITS-1:0]  sh_key [TBL];
  logic [9:0]                     sh_pos [TBL];
  logic                           sh_vld [TBL];
  logic [sris_pkg::SLOT_BITS-1:0] sl_slot [TBL];
  logic [10:0]                    sl_cnt [TBL];
  logic [14:0]                    sl_high [TBL];
  logic                           sl_vld [TBL];
  int unsigned                    wr_pos;
  int unsigned                    capacity;

  answer_t expected_answers[$];
  bit failed = 1'b0;
  bit calm = 1'b0;  // no idling on either side
  int unsigned answers_seen = 0;

  function automatic int find_shred(logic [sris_pkg::KEY_BITS-1:0] k);
    for (int i = 0; i < TBL; i++) if (sh_vld[i] && sh_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int find_slot(logic [sris_pkg::SLOT_BITS-1:0] s);
    for (int i = 0; i < TBL; i++) if (sl_vld[i] && sl_slot[i] == s) return i;
    return -1;
  endfunction

  function automatic void drop_from_slot(logic [sris_pkg::SLOT_BITS-1:0] s, logic [14:0] ix);
    int e;
    bit any;
    logic [14:0] best;
    e = find_slot(s);
    any = 0;
    best = '0;
    if (e < 0) return;
    sl_cnt[e] = sl_cnt[e] - 11'd1;
    if (sl_cnt[e] == 0) begin
      sl_vld[e] = 0;
      return;
    end
    if (ix != sl_high[e]) return;
    for (int i = 0; i < TBL; i++) begin
      if (sh_vld[i] && sh_key[i][sris_pkg::KEY_BITS-1:sris_pkg::INDEX_BITS] == s &&
          sh_key[i][14:0] <= ix && (!any || sh_key[i][14:0] > best)) begin
        best = sh_key[i][14:0];
        any = 1;
      end
    end
    if (any) sl_high[e] = best;
  endfunction

  function automatic answer_t index_answer(sris_pkg::mode_e m, logic [47:0] s,
                                           logic [14:0] ix, logic [10:0] len);
    answer_t a;
    logic [sris_pkg::KEY_BITS-1:0] k;
    int e, se, cap, wp;
    a = '{sris_pkg::ST_MISS, '0, '0, '0, 1'b0};
    k = {s, ix};
    case (m)
      sris_pkg::MODE_INSERT: begin
        if (len > sris_pkg::MAX_PAYLOAD_BYTES) begin
          a.status = sris_pkg::ST_TOOBIG;
          return a;
        end
        e = find_shred(k);
        if (e >= 0) begin
          a = '{sris_pkg::ST_DUP, sh_pos[e], rk_len[sh_pos[e]], ix, 1'b0};
          return a;
        end
        cap = capacity == 0 ? 1 :
              (capacity > sris_pkg::RING_DEPTH ? sris_pkg::RING_DEPTH : capacity);
        wp = wr_pos;
        if (rk_occ[wp]) begin
          e = find_shred(rk_key[wp]);
          if (e >= 0) sh_vld[e] = 0;
          drop_from_slot(rk_key[wp][sris_pkg::KEY_BITS-1:sris_pkg::INDEX_BITS],
                         rk_key[wp][14:0]);
          a.ev = 1'b1;
        end
        rk_key[wp] = k;
        rk_len[wp] = len;
        rk_occ[wp] = 1;
        for (int i = 0; i < TBL; i++) if (!sh_vld[i]) begin
          sh_vld[i] = 1; sh_key[i] = k; sh_pos[i] = wp[9:0];
          break;
        end
        se = find_slot(s);
        if (se < 0) begin
          for (int i = 0; i < TBL; i++) if (!sl_vld[i]) begin
            sl_vld[i] = 1; sl_slot[i] = s; sl_cnt[i] = 11'd1; sl_high[i] = ix;
            break;
          end
        end else begin
          sl_cnt[se] = sl_cnt[se] + 11'd1;
          if (ix > sl_high[se]) sl_high[se] = ix;
        end
        wr_pos = (wp + 1 >= cap) ? 0 : wp + 1;
        a.status = sris_pkg::ST_INSERTED;
        a.pos = wp[9:0];
        a.bytes = len;
        a.idx = ix;
      end
      sris_pkg::MODE_QUERY: begin
        e = find_slot(s) >= 0 ? find_shred(k) : -1;
        if (e >= 0) a = '{sris_pkg::ST_FOUND, sh_pos[e], rk_len[sh_pos[e]], ix, 1'b0};
      end
      sris_pkg::MODE_HIGHEST: begin
        se = find_slot(s);
        if (se >= 0 && sl_high[se] >= ix) begin
          e = find_shred({s, sl_high[se]});
          if (e >= 0) begin
            a = '{sris_pkg::ST_FOUND, sh_pos[e], rk_len[sh_pos[e]], sl_high[se], 1'b0};
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // valid stays high between back-to-back words; it drops only while idling
  task automatic send_word(sris_pkg::mode_e m, logic [47:0] s, logic [14:0] ix,
                           logic [10:0] len);
    while (!calm && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= m;
    s_axis_tdata  <= {6'd0, len, ix, s};
    expected_answers.push_back(index_answer(m, s, ix, len));
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
  endtask

  task automatic write_capacity(int unsigned v);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_CAP; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    capacity = v & 32'h7FF;
  endtask

  // result checker
  always @(posedge clk_i) begin
    answer_t got, exp;
    if (m_axis_tvalid && m_axis_tready) begin
      got = '{sris_pkg::status_e'(m_axis_tuser), m_axis_tdata[9:0], m_axis_tdata[20:10],
              m_axis_tdata[35:21], m_axis_tdata[36]};
      answers_seen++;
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected word %p", $realtime, got);
        failed = 1'b1;
      end else begin
        exp = expected_answers.pop_front();
        if (got !== exp) begin
          $display("%0t: mismatch expected %p actual %p", $realtime, exp, got);
          failed = 1'b1;
        end
      end
    end
    m_axis_tready <= calm || ($urandom_range(99) >= 7);
  end

  function automatic logic [47:0] rand_slot();
    return 48'({$urandom, $urandom});
  endfunction

  task automatic test_directed();
    logic [47:0] big;
    big = 48'hFFFF_FFFF_FFFF;
    send_word(sris_pkg::MODE_QUERY, 48'd0, 15'd0, 11'd0);
    send_word(sris_pkg::MODE_HIGHEST, 48'd0, 15'd0, 11'd0);
    send_word(sris_pkg::MODE_INSERT, 48'd0, 15'd0, 11'd0);
    send_word(sris_pkg::MODE_INSERT, big, 15'h7FFF, 11'd1228);
    send_word(sris_pkg::MODE_INSERT, big, 15'h7FFF, 11'd5);        // duplicate
    send_word(sris_pkg::MODE_INSERT, big, 15'd3, 11'd1229);        // oversize
    send_word(sris_pkg::MODE_INSERT, big, 15'd3, 11'h7FF);
    send_word(sris_pkg::MODE_INSERT, big, 15'd0, 11'd7);
    send_word(sris_pkg::MODE_QUERY, big, 15'h7FFF, 11'h7FF);
    send_word(sris_pkg::MODE_QUERY, big, 15'd3, 11'd0);
    send_word(sris_pkg::MODE_HIGHEST, big, 15'h7FFF, 11'd0);
    send_word(sris_pkg::MODE_HIGHEST, big, 15'd0, 11'd0);
    send_word(sris_pkg::MODE_NONE, big, 15'h7FFF, 11'h7FF);
    send_word(sris_pkg::MODE_HIGHEST, 48'd0, 15'd1, 11'd0);
  endtask

  // small ring: evictions, highest-index queries as the top index is evicted, shrink past position
  task automatic test_eviction();
    logic [47:0] s;
    wait_idle();
    write_capacity(3);
    s = 48'h5A5A;
    send_word(sris_pkg::MODE_INSERT, s, 15'd0, 11'd1);
    send_word(sris_pkg::MODE_INSERT, s, 15'd9, 11'd2);
    send_word(sris_pkg::MODE_INSERT, s, 15'd4, 11'd3);
    send_word(sris_pkg::MODE_INSERT, s, 15'd2, 11'd4);   // evicts index 0
    send_word(sris_pkg::MODE_HIGHEST, s, 15'd0, 11'd0);
    send_word(sris_pkg::MODE_INSERT, 48'd1, 15'd1, 11'd5);  // evicts highest
    send_word(sris_pkg::MODE_HIGHEST, s, 15'd0, 11'd0);
    wait_idle();
    write_capacity(0);
    send_word(sris_pkg::MODE_INSERT, s, 15'd20, 11'd6);
    send_word(sris_pkg::MODE_INSERT, s, 15'd21, 11'd6);
    send_word(sris_pkg::MODE_QUERY, s, 15'd20, 11'd0);
  endtask

  task automatic random_burst(int n, int nslots, int maxidx);
    logic [47:0] pool[8];
    sris_pkg::mode_e m;
    logic [10:0] len;
    for (int i = 0; i < 8; i++) pool[i] = rand_slot();
    for (int i = 0; i < n; i++) begin
      m = sris_pkg::mode_e'($urandom_range(99) < 55 ? 0 : $urandom_range(99) < 50 ? 1 :
                            $urandom_range(99) < 90 ? 2 : 3);
      len = $urandom_range(99) < 8 ? 11'($urandom_range(2047, 1229)) :
            11'($urandom_range(1228));
      send_word(m, $urandom_range(99) < 90 ? pool[$urandom_range(nslots - 1)] : rand_slot(),
                15'($urandom_range(maxidx)), len);
    end
  endtask

  task automatic test_random();
    int caps[5] = '{1, 2, 17, 1024, 2047};
    foreach (caps[c]) begin
      wait_idle();
      write_capacity(caps[c]);
      calm = (c == 2);
      random_burst(260, c < 2 ? 2 : 6, c == 4 ? 32767 : 12);
    end
    calm = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < sris_pkg::RING_DEPTH; i++) rk_occ[i] = 0;
    for (int i = 0; i < TBL; i++) begin
      sh_vld[i] = 0;
      sl_vld[i] = 0;
    end
    wr_pos = 0;
    capacity = 1024;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_eviction();
    test_random();
    wait_idle();
    if (!failed) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
